// ===== src/rmsma_pkg.sv =====
// Package for the windowed RMS moving average block: widths, reset values,
// register indexes and the lane control word.
// No dependencies; every other file of the block but rmsma_ram imports it.
package rmsma_pkg;

    // lane count and fixed field widths
    localparam int LANES      = 3;
    localparam int SAMPLE_W   = 16;
    localparam int SQ_W       = 2 * SAMPLE_W;
    localparam int RMS_W      = 24;
    localparam int FRAC_SHIFT = 16;

    // default sizes of the window and the history ring
    localparam int WINDOW_SAMPLES_DEF = 34;
    localparam int HISTORY_DEPTH_DEF  = 16;

    // configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_C = 2'd2;

    localparam logic [SAMPLE_W-1:0] OFFSET_A_RESET = 16'd18663;
    localparam logic [SAMPLE_W-1:0] OFFSET_B_RESET = 16'd18625;
    localparam logic [SAMPLE_W-1:0] OFFSET_C_RESET = 16'd18625;

    // commands from the sequencer to every lane
    typedef struct packed {
        logic accept;
        logic acc_add;
        logic hist_read;
        logic sqrt_load;
        logic sqrt_step;
        logic hist_update;
        logic mean_mul;
    } lane_ctrl_t;

endpackage

// ===== src/rmsma_if.sv =====
// Valid/ready channel interfaces for the sample words and the mean words.
// Depends on rmsma_pkg for the field widths.
interface rmsma_sample_if
    import rmsma_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic [SAMPLE_W-1:0] sample_c;

    modport source (output valid, output sample_a, output sample_b, output sample_c,
                    input ready);
    modport sink   (input valid, input sample_a, input sample_b, input sample_c,
                    output ready);
endinterface

interface rmsma_mean_if
    import rmsma_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic [RMS_W-1:0] mean_rms_a;
    logic [RMS_W-1:0] mean_rms_b;
    logic [RMS_W-1:0] mean_rms_c;

    modport source (output valid, output mean_rms_a, output mean_rms_b, output mean_rms_c,
                    input ready);
    modport sink   (input valid, input mean_rms_a, input mean_rms_b, input mean_rms_c,
                    output ready);
endinterface

// ===== src/rmsma_ram.sv =====
// Generic single write port RAM with one registered read port.
// No dependencies.
module rmsma_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/rmsma_lane.sv =====
// One channel lane: offset removal, squaring, window sum, digit serial square
// root scaled by the window length, the history ring with its running sum and the mean multiply.
// Depends on rmsma_pkg and rmsma_ram.
module rmsma_lane
    import rmsma_pkg::*;
#(
    parameter int WINDOW_SAMPLES = WINDOW_SAMPLES_DEF,
    parameter int HISTORY_DEPTH  = HISTORY_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lane_ctrl_t          ctrl,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [SAMPLE_W-1:0] offset,
    input  logic                hist_valid,
    input  logic [((HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1)-1:0] hist_addr,
    output logic [RMS_W-1:0]    mean
);

    localparam int AW      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W   = SQ_W + $clog2(WINDOW_SAMPLES);
    localparam int Q_W     = SUM_W + FRAC_SHIFT;
    localparam int HSUM_W  = RMS_W + $clog2(HISTORY_DEPTH);
    localparam int MEAN_SH = HSUM_W + $clog2(HISTORY_DEPTH);
    localparam int RECIP_W = HSUM_W + 1;
    localparam int PROD_W  = HSUM_W + RECIP_W;

    // reciprocal of the history depth, exact for every possible ring sum
    localparam logic [63:0] RECIP_FULL = ((64'd1 << MEAN_SH) + 64'(HISTORY_DEPTH) - 64'd1)
                                         / 64'(HISTORY_DEPTH);
    localparam logic [RECIP_W-1:0] MEAN_RECIP = RECIP_W'(RECIP_FULL);

    // window length times the weight of the top root bit squared
    localparam logic [Q_W-1:0] WB_INIT = Q_W'(WINDOW_SAMPLES) << (2 * (RMS_W - 1));

    logic [SQ_W-1:0]      sq_reg,    sq_next;
    logic [SUM_W-1:0]     sum_reg,   sum_next;
    logic [Q_W-1:0]       x_reg,     x_next;
    logic [Q_W-1:0]       ws_reg,    ws_next;
    logic [Q_W-1:0]       wa_reg,    wa_next;
    logic [Q_W-1:0]       wb_reg,    wb_next;
    logic [RMS_W-1:0]     root_reg,  root_next;
    logic [HSUM_W-1:0]    hsum_reg,  hsum_next;
    logic [PROD_W-1:0]    prod_reg,  prod_next;

    logic signed [SAMPLE_W:0] diff;
    logic [SAMPLE_W-1:0]      mag;
    logic [Q_W:0]             trial;
    logic                     sge;
    logic [RMS_W-1:0]         hist_rdata;
    logic [RMS_W-1:0]         hist_old;

    // history ring of this lane
    rmsma_ram #(
        .WIDTH (RMS_W),
        .DEPTH (HISTORY_DEPTH),
        .AW    (AW)
    ) u_hist (
        .clk   (clk),
        .we    (ctrl.hist_update),
        .waddr (hist_addr),
        .wdata (root_reg),
        .re    (ctrl.hist_read),
        .raddr (hist_addr),
        .rdata (hist_rdata)
    );

    // offset removal and magnitude
    assign diff = $signed({1'b0, sample}) - $signed({1'b0, offset});
    assign mag  = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];

    // root step: keep bit if window * (root + bit)^2 still fits the scaled sum
    assign trial = {1'b0, ws_reg} + {1'b0, wa_reg} + {1'b0, wb_reg};
    assign sge   = {1'b0, x_reg} >= trial;

    // entry leaving the ring, zero until written
    assign hist_old = hist_valid ? hist_rdata : '0;

    always_comb
    begin
        sq_next   = sq_reg;
        sum_next  = sum_reg;
        x_next    = x_reg;
        ws_next   = ws_reg;
        wa_next   = wa_reg;
        wb_next   = wb_reg;
        root_next = root_reg;
        hsum_next = hsum_reg;
        prod_next = prod_reg;

        if (ctrl.accept)
        begin
            sq_next = SQ_W'(mag) * SQ_W'(mag);
        end
        if (ctrl.acc_add)
        begin
            sum_next = sum_reg + SUM_W'(sq_reg);
        end
        if (ctrl.sqrt_load)
        begin
            x_next    = {sum_reg, FRAC_SHIFT'(0)};
            ws_next   = '0;
            wa_next   = '0;
            wb_next   = WB_INIT;
            root_next = '0;
            sum_next  = '0;
        end
        if (ctrl.sqrt_step)
        begin
            ws_next   = sge ? Q_W'(trial) : ws_reg;
            wa_next   = sge ? (wa_reg >> 1) + wb_reg : wa_reg >> 1;
            wb_next   = wb_reg >> 2;
            root_next = {root_reg[RMS_W-2:0], sge};
        end
        if (ctrl.hist_update)
        begin
            hsum_next = hsum_reg - HSUM_W'(hist_old) + HSUM_W'(root_reg);
        end
        if (ctrl.mean_mul)
        begin
            prod_next = PROD_W'(hsum_reg) * PROD_W'(MEAN_RECIP);
        end
    end

    // sums hold model state, the rest is working data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            hsum_reg <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            hsum_reg <= hsum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg   <= sq_next;
        x_reg    <= x_next;
        ws_reg   <= ws_next;
        wa_reg   <= wa_next;
        wb_reg   <= wb_next;
        root_reg <= root_next;
        prod_reg <= prod_next;
    end

    assign mean = prod_reg[MEAN_SH +: RMS_W];

endmodule

// ===== src/windowed_rms_moving_average.sv =====
// Three-channel windowed RMS with a moving average over a history ring.
// Inside a window the block takes one sample word per cycle; each lane squares
// the offset-corrected sample and adds it to its window sum in the cycle after.
// After the last word of a window ready stays low while the lanes work, through
// S_ADD (last add, ring read), S_LOAD_SQRT (root setup), S_SQRT (square root,
// one root bit per step; the division by the window is folded into the root
// compare), S_UPDATE (ring update), S_MEAN (mean multiply) and S_OUT (output,
// which waits for the previous mean word to be taken); then the mean word turns valid.
// The history ring holds one RAM per lane; entries read as zero until written,
// tracked by one valid bit per ring slot, so no clearing pass follows reset.
// Offsets are written through cfg_write/cfg_index/cfg_data.
// Depends on rmsma_pkg, rmsma_if, rmsma_ram and rmsma_lane.
module windowed_rms_moving_average
    import rmsma_pkg::*;
#(
    parameter int WINDOW_SAMPLES = WINDOW_SAMPLES_DEF,
    parameter int HISTORY_DEPTH  = HISTORY_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SAMPLE_W-1:0]  cfg_data,
    rmsma_sample_if.sink         samples,
    rmsma_mean_if.source         means
);

    localparam int AW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_SAMPLES + 1);
    localparam int STEP_W = $clog2(RMS_W);

    typedef enum logic [3:0] {
        S_RUN,
        S_ADD,
        S_LOAD_SQRT,
        S_SQRT,
        S_UPDATE,
        S_MEAN,
        S_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg,   cnt_next;
    logic [STEP_W-1:0]       step_reg,  step_next;
    logic [AW-1:0]           wp_reg,    wp_next;
    logic                    pend_reg,  pend_next;
    logic [HISTORY_DEPTH-1:0] hvalid_reg, hvalid_next;
    logic                    ovalid_reg, ovalid_next;
    logic [RMS_W-1:0]        omean_reg  [LANES];
    logic [RMS_W-1:0]        omean_next [LANES];

    logic [SAMPLE_W-1:0]     offset_reg [LANES];
    logic [SAMPLE_W-1:0]     sample_vec [LANES];
    logic [RMS_W-1:0]        lane_mean  [LANES];
    lane_ctrl_t              ctrl;
    logic                    accept;
    logic                    last;

    assign accept = samples.valid && samples.ready;
    assign last   = cnt_reg == CNT_W'(WINDOW_SAMPLES - 1);

    assign sample_vec[0] = samples.sample_a;
    assign sample_vec[1] = samples.sample_b;
    assign sample_vec[2] = samples.sample_c;

    // offset registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg[0] <= OFFSET_A_RESET;
            offset_reg[1] <= OFFSET_B_RESET;
            offset_reg[2] <= OFFSET_C_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_OFFSET_A: offset_reg[0] <= cfg_data;
                REG_OFFSET_B: offset_reg[1] <= cfg_data;
                REG_OFFSET_C: offset_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        step_next   = step_reg;
        wp_next     = wp_reg;
        pend_next   = accept;
        hvalid_next = hvalid_reg;
        ovalid_next = ovalid_reg;
        omean_next  = omean_reg;
        ctrl        = '0;
        ctrl.accept  = accept;
        ctrl.acc_add = pend_reg;

        if (means.valid && means.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_RUN:
            begin
                if (accept)
                begin
                    if (last)
                    begin
                        cnt_next   = '0;
                        state_next = S_ADD;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            S_ADD:
            begin
                ctrl.hist_read = 1'b1;
                state_next     = S_LOAD_SQRT;
            end
            S_LOAD_SQRT:
            begin
                ctrl.sqrt_load = 1'b1;
                step_next      = '0;
                state_next     = S_SQRT;
            end
            S_SQRT:
            begin
                ctrl.sqrt_step = 1'b1;
                step_next      = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(RMS_W - 1))
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                ctrl.hist_update = 1'b1;
                hvalid_next      = hvalid_reg | (HISTORY_DEPTH'(1) << wp_reg);
                wp_next          = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0
                                                                        : wp_reg + AW'(1);
                state_next       = S_MEAN;
            end
            S_MEAN:
            begin
                ctrl.mean_mul = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                // merge the lane means into one output word
                if (!ovalid_reg || means.ready)
                begin
                    ovalid_next = 1'b1;
                    omean_next  = lane_mean;
                    state_next  = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_RUN;
            cnt_reg    <= '0;
            step_reg   <= '0;
            wp_reg     <= '0;
            pend_reg   <= 1'b0;
            hvalid_reg <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < LANES; i++)
            begin
                omean_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            step_reg   <= step_next;
            wp_reg     <= wp_next;
            pend_reg   <= pend_next;
            hvalid_reg <= hvalid_next;
            ovalid_reg <= ovalid_next;
            omean_reg  <= omean_next;
        end
    end

    // channel lanes
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        rmsma_lane #(
            .WINDOW_SAMPLES (WINDOW_SAMPLES),
            .HISTORY_DEPTH  (HISTORY_DEPTH)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .sample     (sample_vec[g]),
            .offset     (offset_reg[g]),
            .hist_valid (hvalid_reg[wp_reg]),
            .hist_addr  (wp_reg),
            .mean       (lane_mean[g])
        );
    end

    // channel handshakes
    assign samples.ready    = (state_reg == S_RUN);
    assign means.valid      = ovalid_reg;
    assign means.mean_rms_a = omean_reg[0];
    assign means.mean_rms_b = omean_reg[1];
    assign means.mean_rms_c = omean_reg[2];

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for windowed_rms_moving_average: random and directed sample words,
// offset changes while idle, mean words checked against an in-bench predictor.
// Depends on rmsma_pkg, rmsma_if and the block's RTL.
module tb;
    import rmsma_pkg::*;

    localparam int WINDOW       = WINDOW_SAMPLES_DEF;
    localparam int HISTORY      = HISTORY_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 200;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] a;
        logic [SAMPLE_W-1:0] b;
        logic [SAMPLE_W-1:0] c;
    } sample_word_t;

    typedef struct packed {
        logic [RMS_W-1:0] a;
        logic [RMS_W-1:0] b;
        logic [RMS_W-1:0] c;
    } mean_word_t;

    typedef enum logic [1:0] { RX_ALWAYS, RX_RANDOM, RX_SLOW } rx_mode_e;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SAMPLE_W-1:0]  cfg_data;

    rmsma_sample_if sample_ch ();
    rmsma_mean_if   mean_ch ();

    windowed_rms_moving_average #(
        .WINDOW_SAMPLES(WINDOW),
        .HISTORY_DEPTH (HISTORY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .samples  (sample_ch),
        .means    (mean_ch)
    );

    always #10 clk = ~clk;

    // stimulus and scoreboard state
    sample_word_t sample_backlog [$];
    mean_word_t   expected_means [$];
    int unsigned  words_queued    = 0;
    int unsigned  words_accepted  = 0;
    int unsigned  means_checked   = 0;
    int unsigned  mismatch_count  = 0;
    int unsigned  offset_settings = 1;

    // predictor state
    logic [SAMPLE_W-1:0] lane_offset [LANES];
    int unsigned         window_fill;
    logic [63:0]         square_acc [LANES];
    logic [RMS_W-1:0]    rms_ring [LANES][HISTORY];
    logic [63:0]         ring_total [LANES];
    int unsigned         ring_slot;

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] probe;
        logic [63:0] rest;
        root  = '0;
        probe = 64'd1 << 62;
        rest  = v;
        while (probe > rest)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rest >= root + probe)
            begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic void clear_rms_state();
        lane_offset[0] = OFFSET_A_RESET;
        lane_offset[1] = OFFSET_B_RESET;
        lane_offset[2] = OFFSET_C_RESET;
        window_fill = 0;
        ring_slot   = 0;
        for (int k = 0; k < LANES; k++)
        begin
            square_acc[k] = '0;
            ring_total[k] = '0;
            for (int i = 0; i < HISTORY; i++)
                rms_ring[k][i] = '0;
        end
    endfunction

    // one accepted sample word: accumulate, and at window end push the means
    function automatic void predict_means(sample_word_t w);
        logic [SAMPLE_W-1:0] raw [LANES];
        logic [SAMPLE_W-1:0] mag;
        logic [63:0]         quot;
        logic [RMS_W-1:0]    rms;
        logic [RMS_W-1:0]    mean [LANES];
        mean_word_t          result;
        raw[0] = w.a;
        raw[1] = w.b;
        raw[2] = w.c;
        for (int k = 0; k < LANES; k++)
        begin
            mag = (raw[k] >= lane_offset[k]) ? raw[k] - lane_offset[k]
                                             : lane_offset[k] - raw[k];
            square_acc[k] = square_acc[k] + 64'(mag) * 64'(mag);
        end
        window_fill++;
        if (window_fill < WINDOW)
            return;
        window_fill = 0;
        for (int k = 0; k < LANES; k++)
        begin
            quot = (square_acc[k] << FRAC_SHIFT) / 64'(WINDOW);
            rms  = RMS_W'(isqrt64(quot));
            ring_total[k] = ring_total[k] - 64'(rms_ring[k][ring_slot]) + 64'(rms);
            rms_ring[k][ring_slot] = rms;
            square_acc[k] = '0;
            mean[k] = RMS_W'(ring_total[k] / 64'(HISTORY));
        end
        ring_slot = (ring_slot + 1 >= HISTORY) ? 0 : ring_slot + 1;
        result.a = mean[0];
        result.b = mean[1];
        result.c = mean[2];
        expected_means.push_back(result);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // sample driver: bursts of random length separated by random gaps
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge clk)
    begin
        sample_word_t next_word;
        if (!rst_n)
        begin
            sample_ch.valid    <= 1'b0;
            sample_ch.sample_a <= '0;
            sample_ch.sample_b <= '0;
            sample_ch.sample_c <= '0;
            burst_left = $urandom_range(1, 60);
            gap_left   = 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                predict_means({sample_ch.sample_a, sample_ch.sample_b, sample_ch.sample_c});
                words_accepted++;
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    sample_ch.valid <= 1'b0;
                end
                else if (sample_backlog.size() != 0)
                begin
                    next_word = sample_backlog.pop_front();
                    sample_ch.valid    <= 1'b1;
                    sample_ch.sample_a <= next_word.a;
                    sample_ch.sample_b <= next_word.b;
                    sample_ch.sample_c <= next_word.c;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 60);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            3:       gap_left = $urandom_range(10, 40);
                            default: gap_left = $urandom_range(1, 4);
                        endcase
                    end
                    else
                        burst_left--;
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // mean monitor: compares each word, stalls on its own mode schedule
    rx_mode_e    rx_mode;
    int unsigned rx_mode_left;

    always @(posedge clk)
    begin
        mean_word_t want;
        if (!rst_n)
        begin
            mean_ch.ready <= 1'b0;
            rx_mode      = RX_ALWAYS;
            rx_mode_left = 0;
        end
        else
        begin
            if (mean_ch.valid && mean_ch.ready)
            begin
                if (expected_means.size() == 0)
                    report_mismatch("unexpected mean word", mean_ch.mean_rms_a, 0);
                else
                begin
                    want = expected_means.pop_front();
                    means_checked++;
                    if (mean_ch.mean_rms_a !== want.a)
                        report_mismatch("mean_rms_a", mean_ch.mean_rms_a, want.a);
                    if (mean_ch.mean_rms_b !== want.b)
                        report_mismatch("mean_rms_b", mean_ch.mean_rms_b, want.b);
                    if (mean_ch.mean_rms_c !== want.c)
                        report_mismatch("mean_rms_c", mean_ch.mean_rms_c, want.c);
                end
            end
            if (rx_mode_left == 0)
            begin
                rx_mode      = rx_mode_e'($urandom_range(0, 2));
                rx_mode_left = $urandom_range(50, 400);
            end
            else
                rx_mode_left--;
            case (rx_mode)
                RX_ALWAYS: mean_ch.ready <= 1'b1;
                RX_RANDOM: mean_ch.ready <= 1'($urandom_range(0, 1));
                default:   mean_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic push_word(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                             logic [SAMPLE_W-1:0] c);
        sample_backlog.push_back({a, b, c});
        words_queued++;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] zero);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return zero + SAMPLE_W'($urandom_range(0, 512)) - 16'd256;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // block idle: every word taken, every mean seen, lanes settled
    task automatic wait_idle();
        @(negedge clk);
        while (sample_backlog.size() != 0 || words_accepted != words_queued
               || expected_means.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_offset(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx < LANES)
            lane_offset[idx] = value;
    endtask

    task automatic set_offsets(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                               logic [SAMPLE_W-1:0] c);
        write_offset(REG_OFFSET_A, a);
        write_offset(REG_OFFSET_B, b);
        write_offset(REG_OFFSET_C, c);
        offset_settings++;
        @(negedge clk);
    endtask

    task automatic queue_random(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            push_word(pick_sample(lane_offset[0]), pick_sample(lane_offset[1]),
                      pick_sample(lane_offset[2]));
    endtask

    // main sequence
    initial
    begin
        cfg_write          <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        clear_rms_state();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // out-of-range index must leave the reset offsets alone
        write_offset(REG_UNUSED, SAMPLE_W'($urandom));
        @(negedge clk);

        // directed words at reset offsets
        push_word('0, '0, '0);
        push_word('1, '1, '1);
        push_word(OFFSET_A_RESET, OFFSET_B_RESET, OFFSET_C_RESET);
        push_word('0, '1, '0);
        push_word('1, '0, '1);
        push_word(16'hAAAA, 16'h5555, 16'hAAAA);
        push_word(16'h5555, 16'hAAAA, 16'h5555);
        push_word(OFFSET_A_RESET + 16'd1, OFFSET_B_RESET - 16'd1, OFFSET_C_RESET);
        push_word(16'h0001, 16'h8000, 16'h7FFF);
        push_word(16'h8000, 16'h7FFF, 16'h0001);
        for (int i = 0; i < 10; i++)
            push_word('1, '0, OFFSET_C_RESET);
        queue_random(300);
        wait_idle();

        // offset extremes, then random and mixed settings
        set_offsets('0, '0, '0);
        queue_random(250);
        wait_idle();

        set_offsets('1, '1, '1);
        queue_random(250);
        wait_idle();

        set_offsets(SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        queue_random(250);
        wait_idle();

        set_offsets('0, '1, SAMPLE_W'($urandom));
        write_offset(REG_UNUSED, SAMPLE_W'($urandom));
        @(negedge clk);
        queue_random(250);
        wait_idle();

        set_offsets(SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        queue_random(300);
        wait_idle();

        $display("run covered %0d sample words and %0d mean words over %0d offset settings",
                 words_accepted, means_checked, offset_settings);
        if (mismatch_count == 0 && expected_means.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("timeout after %0d sample words", words_accepted);
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/rmsma_pkg.sv
src/rmsma_if.sv
src/rmsma_ram.sv
src/rmsma_lane.sv
src/windowed_rms_moving_average.sv
tb/tb.sv
